[design/spmf_pkg.sv]
// Shared types and constants of the strict-priority multi-queue.
// Used by spmf_tier and strict_priority_multi_fifo; no dependencies.
package spmf_pkg;

	// Default sizing, handed down as top-level parameter defaults.
	localparam int MAX_TIERS_DEF  = 8;
	localparam int TIER_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF    = 16;

	// Fixed field widths of the stream words.
	localparam int ID_W       = 16;
	localparam int TIER_IDX_W = 3;
	localparam int TIERS_W    = 4;

	// Input word: item_id, tier_index, padded to whole bytes.
	localparam int IN_FIELDS_W = ID_W + TIER_IDX_W;
	localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;

	// Result word: popped_id, popped_valid, dropped, all_empty, first_id, last_id.
	localparam int OUT_FIELDS_W = 3 * ID_W + 3;
	localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Request kinds carried on the input tuser.
	typedef enum logic {
		REQ_ENQUEUE = 1'b0,
		REQ_DEQUEUE = 1'b1
	} req_t;

endpackage

[design/spmf_tier.sv]
// One priority tier: a shift-line FIFO whose head always sits in slot 0.
// Depends on spmf_pkg for parameter defaults.
module spmf_tier #(
	parameter int Depth  = spmf_pkg::TIER_DEPTH_DEF,
	parameter int IdBits = spmf_pkg::ID_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              pop,
	input  logic [IdBits-1:0] push_data,
	output logic [IdBits-1:0] head,
	output logic [IdBits-1:0] head_next,
	output logic [IdBits-1:0] tail,
	output logic              empty,
	output logic              single,
	output logic              full
);

	localparam int CntW = $clog2(Depth + 1);

	logic [CntW-1:0]   count_q;
	logic [IdBits-1:0] slot_q [Depth];
	logic [IdBits-1:0] tail_q;

	// Entry count; push and pop never come together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= count_q + CntW'(1);
		end else if (pop) begin
			count_q <= count_q - CntW'(1);
		end
	end

	// Each slot shifts toward the head on a pop, or takes the new word when it is the next free one.
	for (genvar i = 0; i < Depth; i++) begin : g_slot
		if (i < Depth - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (pop) begin
					slot_q[i] <= slot_q[i+1];
				end else if (push && count_q == CntW'(i)) begin
					slot_q[i] <= push_data;
				end
			end
		end else begin : g_end
			always_ff @(posedge clk) begin
				if (push && count_q == CntW'(i)) begin
					slot_q[i] <= push_data;
				end
			end
		end
	end

	// The most recently written word is the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			tail_q <= push_data;
		end
	end

	assign head      = slot_q[0];
	assign head_next = slot_q[1];
	assign tail      = tail_q;
	assign empty     = (count_q == '0);
	assign single    = (count_q == CntW'(1));
	assign full      = (count_q == CntW'(Depth));

	// The top level must never push into a full tier or pop an empty one.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full tier");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty tier");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("tier count beyond depth");

endmodule

[design/strict_priority_multi_fifo.sv]
// Top level of the strict-priority multi-queue: input stage, tier FIFOs, result register.
// Depends on spmf_pkg and spmf_tier.
//
//  Channel  | Direction | Handshake          | Word
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata: item_id, tier_index; tuser: req_type
//  m_*      | out       | m_tvalid/m_tready  | tdata: popped_id, popped_valid, dropped,
//           |           |                    |        all_empty, first_id, last_id
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_data: tiers_in_use
//
// One word is accepted per cycle unless the output stalls. The single input stage, where
// tier selection and one FIFO update happen, sets that rate. Reset empties every tier and
// sets the tier count to one. While a result waits on a low m_tready, the result register
// holds, the input stage keeps one word, and s_tready then falls.
module strict_priority_multi_fifo #(
	parameter int MAX_TIERS  = spmf_pkg::MAX_TIERS_DEF,
	parameter int TIER_DEPTH = spmf_pkg::TIER_DEPTH_DEF,
	parameter int ID_BITS    = spmf_pkg::ID_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// item_id [15:0], tier_index [18:16], zero pad above
	input  logic [spmf_pkg::IN_W-1:0]    s_tdata,
	// req_type [0]
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// popped_id [15:0], popped_valid [16], dropped [17], all_empty [18],
	// first_id [34:19], last_id [50:35], zero pad above
	output logic [spmf_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [spmf_pkg::TIERS_W-1:0] cfg_data
);

	import spmf_pkg::*;

	// Input stage.
	logic                  valid_s1;
	req_t                  req_s1;
	logic [ID_BITS-1:0]    id_s1;
	logic [TIER_IDX_W-1:0] tier_s1;

	// Configuration and result registers.
	logic [TIERS_W-1:0] tiers_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	// Tier status and control.
	logic [MAX_TIERS-1:0] t_empty, t_single, t_full;
	logic [ID_BITS-1:0]   t_head [MAX_TIERS];
	logic [ID_BITS-1:0]   t_next [MAX_TIERS];
	logic [ID_BITS-1:0]   t_tail [MAX_TIERS];
	logic [MAX_TIERS-1:0] push_w, pop_w;

	// Step logic.
	logic                 out_load, advance, is_enq, is_deq;
	logic [MAX_TIERS-1:0] act, enq_hit, cand, deq_pick, deq_hit, ne_nx;
	logic [MAX_TIERS-1:0] first_pick, ne_rev, last_rev, last_pick;
	logic [ID_BITS-1:0]   head_nx [MAX_TIERS];
	logic [ID_BITS-1:0]   tail_nx [MAX_TIERS];
	logic [ID_BITS-1:0]   popped_id_w, first_id_w, last_id_w;
	logic                 popped_valid_w, dropped_w, all_empty_w;
	logic [OUT_W-1:0]     result_w;

	assign out_load  = !m_tvalid_q || m_tready;
	assign advance   = valid_s1 && out_load;
	assign s_tready  = !valid_s1 || out_load;
	assign cfg_ready = 1'b1;

	// Tier count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiers_q <= TIERS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			tiers_q <= cfg_data;
		end
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= req_t'(s_tuser);
			id_s1   <= ID_BITS'(s_tdata[ID_W-1:0]);
			tier_s1 <= s_tdata[ID_W +: TIER_IDX_W];
		end
	end

	// Tier selection and the state each tier shows after this step.
	always_comb begin
		is_enq = valid_s1 && (req_s1 == REQ_ENQUEUE);
		is_deq = valid_s1 && (req_s1 == REQ_DEQUEUE);
		for (int t = 0; t < MAX_TIERS; t++) begin
			act[t]     = t < int'(tiers_q);
			enq_hit[t] = is_enq && act[t] && (int'(tier_s1) == t) && !t_full[t];
			cand[t]    = act[t] && !t_empty[t];
		end
		deq_pick = cand & (~cand + MAX_TIERS'(1));
		deq_hit  = is_deq ? deq_pick : '0;
		for (int t = 0; t < MAX_TIERS; t++) begin
			ne_nx[t] = act[t] && (enq_hit[t] ||
				(!t_empty[t] && !(deq_hit[t] && t_single[t])));
			if (deq_hit[t]) begin
				head_nx[t] = t_next[t];
			end else if (enq_hit[t] && t_empty[t]) begin
				head_nx[t] = id_s1;
			end else begin
				head_nx[t] = t_head[t];
			end
			tail_nx[t] = enq_hit[t] ? id_s1 : t_tail[t];
		end
	end

	// Lowest and highest non-empty tiers after the step.
	always_comb begin
		first_pick = ne_nx & (~ne_nx + MAX_TIERS'(1));
		for (int t = 0; t < MAX_TIERS; t++) begin
			ne_rev[t] = ne_nx[MAX_TIERS-1-t];
		end
		last_rev = ne_rev & (~ne_rev + MAX_TIERS'(1));
		for (int t = 0; t < MAX_TIERS; t++) begin
			last_pick[t] = last_rev[MAX_TIERS-1-t];
		end
	end

	// One-hot selection of the reported words.
	always_comb begin
		popped_id_w = '0;
		first_id_w  = '0;
		last_id_w   = '0;
		for (int t = 0; t < MAX_TIERS; t++) begin
			popped_id_w = popped_id_w | (deq_hit[t] ? t_head[t] : '0);
			first_id_w  = first_id_w | (first_pick[t] ? head_nx[t] : '0);
			last_id_w   = last_id_w | (last_pick[t] ? tail_nx[t] : '0);
		end
		popped_valid_w = |deq_hit;
		dropped_w      = is_enq && !(|enq_hit);
		all_empty_w    = !(|ne_nx);
		result_w = OUT_W'({16'(last_id_w), 16'(first_id_w), all_empty_w, dropped_w,
			popped_valid_w, 16'(popped_id_w)});
	end

	assign push_w = advance ? enq_hit : '0;
	assign pop_w  = advance ? deq_hit : '0;

	// One FIFO per tier.
	for (genvar t = 0; t < MAX_TIERS; t++) begin : g_tier
		spmf_tier #(
			.Depth  (TIER_DEPTH),
			.IdBits (ID_BITS)
		) u_tier (
			.clk       (clk),
			.arst_n    (arst_n),
			.push      (push_w[t]),
			.pop       (pop_w[t]),
			.push_data (id_s1),
			.head      (t_head[t]),
			.head_next (t_next[t]),
			.tail      (t_tail[t]),
			.empty     (t_empty[t]),
			.single    (t_single[t]),
			.full      (t_full[t])
		);
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= result_w;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// At most one tier is touched per word, and never by both a push and a pop.
	a_one_touch: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(push_w | pop_w) && !((|push_w) && (|pop_w)))
		else $error("more than one tier update in a cycle");
	// A word never both pops and drops.
	a_pop_or_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(m_tdata_q[ID_W] && m_tdata_q[ID_W+1]))
		else $error("result both popped and dropped");
	// An empty result reports zero first and last words.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tdata_q[ID_W+2]) |->
		(m_tdata_q[ID_W+3 +: 2*ID_W] == '0))
		else $error("empty result with nonzero first or last word");
	// An enqueue never reports a popped word.
	a_enq_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_enq) |=> !m_tdata_q[ID_W])
		else $error("enqueue reported a popped word");

endmodule

[bench/strict_priority_multi_fifo_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for strict_priority_multi_fifo: directed table, then random traffic.
// Depends on spmf_pkg and the design; compares each result with predicted or hand-set words.
module strict_priority_multi_fifo_tb;
	import spmf_pkg::*;

	localparam int NT     = MAX_TIERS_DEF;
	localparam int ND     = TIER_DEPTH_DEF;
	localparam int SLOT_W = $clog2(ND);
	localparam int FILL_W = $clog2(ND) + 1;

	// Result word as unpacked from m_tdata, last field at the top.
	typedef struct packed {
		logic [ID_W-1:0] last_id;
		logic [ID_W-1:0] first_id;
		logic            all_empty;
		logic            dropped;
		logic            popped_valid;
		logic [ID_W-1:0] popped_id;
	} queue_result_t;

	// One row of the directed table: either a tier-count write or a request word.
	typedef struct packed {
		logic                  is_cfg;
		logic [TIERS_W-1:0]    cfg_val;
		req_t                  req;
		logic [ID_W-1:0]       id;
		logic [TIER_IDX_W-1:0] tier;
		logic                  typed;
		queue_result_t         want;
	} step_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata  = '0;
	logic                s_tuser  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [TIERS_W-1:0]  cfg_data  = '0;

	// Predictor state: one circular buffer per tier plus the tier count.
	logic [ID_W-1:0]    id_store [NT][ND];
	logic [SLOT_W-1:0]  head_at [NT];
	logic [SLOT_W-1:0]  tail_at [NT];
	logic [FILL_W-1:0]  fill_at [NT];
	logic [TIERS_W-1:0] tier_count;

	queue_result_t expected_q [$];
	step_row_t     dir_table [$];
	int            mismatches = 0;
	int            burst_left = 0;
	logic [7:0]    rx_tick = '0;
	int unsigned   cfg_plan [12] = '{8, 3, 15, 0, 8, 1, 11, 2, 8, 6, 4, 7};

	strict_priority_multi_fifo dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] p);
		return (p == SLOT_W'(ND - 1)) ? '0 : p + 1'b1;
	endfunction

	// Applies one request to the predicted queue state and returns the result word it causes.
	function automatic queue_result_t queue_step(req_t req, logic [ID_W-1:0] id,
			logic [TIER_IDX_W-1:0] tier);
		queue_result_t r;
		int            active;
		bit            found;
		logic [SLOT_W-1:0] last_slot;
		r = '0;
		r.all_empty = 1'b1;
		active = (tier_count > NT) ? NT : int'(tier_count);
		if (req == REQ_ENQUEUE) begin
			if (tier >= active || fill_at[tier] >= ND) begin
				r.dropped = 1'b1;
			end else begin
				id_store[tier][tail_at[tier]] = id;
				tail_at[tier] = next_slot(tail_at[tier]);
				fill_at[tier] = fill_at[tier] + 1'b1;
			end
		end else begin
			found = 0;
			for (int t = 0; t < active; t++) begin
				if (!found && fill_at[t] != 0) begin
					r.popped_id    = id_store[t][head_at[t]];
					r.popped_valid = 1'b1;
					head_at[t]     = next_slot(head_at[t]);
					fill_at[t]     = fill_at[t] - 1'b1;
					found          = 1;
				end
			end
		end
		// Status fields are taken after the update.
		found = 0;
		for (int t = 0; t < active; t++) begin
			if (!found && fill_at[t] != 0) begin
				r.first_id  = id_store[t][head_at[t]];
				r.all_empty = 1'b0;
				found       = 1;
			end
		end
		found = 0;
		for (int t = active - 1; t >= 0; t--) begin
			if (!found && fill_at[t] != 0) begin
				last_slot = (tail_at[t] == '0) ? SLOT_W'(ND - 1) : tail_at[t] - 1'b1;
				r.last_id = id_store[t][last_slot];
				found     = 1;
			end
		end
		return r;
	endfunction

	function automatic queue_result_t result_of(logic [ID_W-1:0] pid, logic pv, logic dr,
			logic ae, logic [ID_W-1:0] f, logic [ID_W-1:0] l);
		queue_result_t r;
		r.popped_id    = pid;
		r.popped_valid = pv;
		r.dropped      = dr;
		r.all_empty    = ae;
		r.first_id     = f;
		r.last_id      = l;
		return r;
	endfunction

	function automatic step_row_t item_row(req_t req, logic [ID_W-1:0] id,
			logic [TIER_IDX_W-1:0] tier, logic typed, queue_result_t want);
		step_row_t row;
		row         = '0;
		row.req     = req;
		row.id      = id;
		row.tier    = tier;
		row.typed   = typed;
		row.want    = want;
		return row;
	endfunction

	function automatic step_row_t cfg_row(logic [TIERS_W-1:0] v);
		step_row_t row;
		row         = '0;
		row.is_cfg  = 1'b1;
		row.cfg_val = v;
		return row;
	endfunction

	function automatic logic [TIER_IDX_W-1:0] pick_tier(int active);
		return (active > 0) ? TIER_IDX_W'($urandom_range(0, active - 1))
		                    : TIER_IDX_W'($urandom_range(0, NT - 1));
	endfunction

	// Sender pacing: bursts of random length, each followed by a random gap.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
			                                          : $urandom_range(1, 10);
		end
	endtask

	// Offers one request word, waits for its acceptance and records what it should produce.
	task automatic send_request(req_t req, logic [ID_W-1:0] id, logic [TIER_IDX_W-1:0] tier,
			logic typed, queue_result_t want);
		logic [IN_W-1:0] word;
		queue_result_t   predicted;
		word = '0;
		word[ID_W-1:0] = id;
		word[ID_W +: TIER_IDX_W] = tier;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= req;
		do @(posedge clk); while (!s_tready);
		predicted = queue_step(req, id, tier);
		expected_q.push_back(typed ? want : predicted);
		pace();
	endtask

	// Stops the sender until every outstanding result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tier_count(logic [TIERS_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		tier_count = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic note_mismatch(string field, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %h, got %h", field, want, got);
	endtask

	// Receiver: ready pattern rotates between open, random, toggling and mostly stalled.
	always @(posedge clk) begin
		rx_tick = rx_tick + 1'b1;
		case (rx_tick[7:6])
			2'd0: begin
				m_tready <= 1'b1;
			end
			2'd1: begin
				m_tready <= ($urandom_range(0, 9) < 7);
			end
			2'd2: begin
				m_tready <= rx_tick[0];
			end
			default: begin
				m_tready <= (rx_tick[3:0] >= 4'd10);
			end
		endcase
	end

	// Result checker: each accepted word is compared with the oldest expectation.
	always @(posedge clk) begin : watch_results
		queue_result_t got;
		queue_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[OUT_FIELDS_W-1:0];
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got.popped_id !== want.popped_id)
					note_mismatch("popped_id", want.popped_id, got.popped_id);
				if (got.popped_valid !== want.popped_valid)
					note_mismatch("popped_valid", ID_W'(want.popped_valid),
					              ID_W'(got.popped_valid));
				if (got.dropped !== want.dropped)
					note_mismatch("dropped", ID_W'(want.dropped), ID_W'(got.dropped));
				if (got.all_empty !== want.all_empty)
					note_mismatch("all_empty", ID_W'(want.all_empty), ID_W'(got.all_empty));
				if (got.first_id !== want.first_id)
					note_mismatch("first_id", want.first_id, got.first_id);
				if (got.last_id !== want.last_id)
					note_mismatch("last_id", want.last_id, got.last_id);
			end
		end
	end

	initial begin : stimulus
		step_row_t     row;
		queue_result_t empty_res;
		queue_result_t drop_res;
		int            active;
		int            left;
		int            len;
		int            pick;
		bit            paused;
		logic [TIER_IDX_W-1:0] burst_tier;

		for (int t = 0; t < NT; t++) begin
			head_at[t] = '0;
			tail_at[t] = '0;
			fill_at[t] = '0;
		end
		tier_count = 4'd1;

		// Hand-checked rows: empty dequeue and refused enqueue leave nothing queued.
		empty_res = result_of(16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000);
		drop_res  = result_of(16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0000);

		// Single tier after reset: empty dequeue, bad tier, extreme identifiers.
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'h0000, 3'd0, 1'b1, empty_res));
		dir_table.push_back(item_row(REQ_ENQUEUE, 16'h1234, 3'd7, 1'b1, drop_res));
		dir_table.push_back(item_row(REQ_ENQUEUE, 16'hFFFF, 3'd0, 1'b0, '0));
		dir_table.push_back(item_row(REQ_ENQUEUE, 16'h0000, 3'd0, 1'b0, '0));
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'hFFFF, 3'd7, 1'b0, '0));
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'h0000, 3'd0, 1'b0, '0));
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'h0000, 3'd0, 1'b1, empty_res));
		// No active tier at all.
		dir_table.push_back(cfg_row(4'd0));
		dir_table.push_back(item_row(REQ_ENQUEUE, 16'hAAAA, 3'd0, 1'b1, drop_res));
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'h5555, 3'd0, 1'b1, empty_res));
		// An oversized count saturates, so tier 7 accepts.
		dir_table.push_back(cfg_row(4'd15));
		dir_table.push_back(item_row(REQ_ENQUEUE, 16'h5555, 3'd7, 1'b0, '0));
		dir_table.push_back(item_row(REQ_ENQUEUE, 16'h0F0F, 3'd3, 1'b0, '0));
		dir_table.push_back(item_row(REQ_ENQUEUE, 16'h8001, 3'd0, 1'b0, '0));
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'h0000, 3'd0, 1'b0, '0));
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'h0000, 3'd0, 1'b0, '0));
		// Shrinking the count hides tier 7, growing it again brings its entry back.
		dir_table.push_back(cfg_row(4'd2));
		dir_table.push_back(item_row(REQ_ENQUEUE, 16'h7777, 3'd1, 1'b0, '0));
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'h0000, 3'd0, 1'b0, '0));
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'h0000, 3'd0, 1'b1, empty_res));
		dir_table.push_back(cfg_row(4'd8));
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'h0000, 3'd0, 1'b0, '0));
		dir_table.push_back(item_row(REQ_DEQUEUE, 16'h0000, 3'd0, 1'b1, empty_res));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			row = dir_table[i];
			if (row.is_cfg)
				write_tier_count(row.cfg_val);
			else
				send_request(row.req, row.id, row.tier, row.typed, row.want);
		end

		// Random traffic in phases, one tier count per phase.
		paused = 0;
		for (int phase = 0; phase < 12; phase++) begin
			write_tier_count(TIERS_W'(cfg_plan[phase]));
			left = 40;
			while (left > 0) begin
				active = (tier_count > NT) ? NT : int'(tier_count);
				if (phase == 5 && left < 20 && !paused) begin
					drain();
					paused = 1;
				end
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					// Burst into one tier, at times long enough to pass its depth and hit the full case.
					burst_tier = pick_tier(active);
					len = $urandom_range(12, 20);
					for (int k = 0; k < len; k++)
						send_request(REQ_ENQUEUE, ID_W'($urandom_range(0, 65535)), burst_tier,
						             1'b0, '0);
				end else if (pick < 4) begin
					// Run of dequeues; the unused fields carry random content.
					len = $urandom_range(5, 20);
					for (int k = 0; k < len; k++)
						send_request(REQ_DEQUEUE, ID_W'($urandom_range(0, 65535)),
						             TIER_IDX_W'($urandom_range(0, NT - 1)), 1'b0, '0);
				end else if (pick < 9) begin
					// Mixed traffic aimed at the active tiers.
					len = $urandom_range(4, 16);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 9) < 6)
							send_request(REQ_ENQUEUE, ID_W'($urandom_range(0, 65535)),
							             pick_tier(active), 1'b0, '0);
						else
							send_request(REQ_DEQUEUE, ID_W'($urandom_range(0, 65535)),
							             TIER_IDX_W'($urandom_range(0, NT - 1)), 1'b0, '0);
					end
				end else begin
					// Noise: any request kind into any tier.
					len = $urandom_range(2, 6);
					for (int k = 0; k < len; k++)
						send_request(req_t'($urandom_range(0, 1)),
						             ID_W'($urandom_range(0, 65535)),
						             TIER_IDX_W'($urandom_range(0, NT - 1)), 1'b0, '0);
				end
				left -= len;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[strict_priority_multi_fifo.f]
design/spmf_pkg.sv
design/spmf_tier.sv
design/strict_priority_multi_fifo.sv
bench/strict_priority_multi_fifo_tb.sv
